// ===== src/yuv2rgb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the YUYV 4:2:2 to RGB888 converter.
// Holds the payload structs and the shared chroma term type; no dependencies.
package yuv2rgb_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned TermW = 14;   // signed width of one weighted chroma term

    typedef struct packed {
        logic [ByteW-1:0] first_luma;
        logic [ByteW-1:0] chroma_blue;
        logic [ByteW-1:0] second_luma;
        logic [ByteW-1:0] chroma_red;
        logic             end_of_frame;
    } t_yuyv_in;

    typedef struct packed {
        logic [ByteW-1:0] first_red;
        logic [ByteW-1:0] first_green;
        logic [ByteW-1:0] first_blue;
        logic [ByteW-1:0] second_red;
        logic [ByteW-1:0] second_green;
        logic [ByteW-1:0] second_blue;
        logic             frame_done;
    } t_rgb_out;

    // Chroma contributions in units of 1/32, shared by both pixel lanes.
    typedef struct packed {
        logic signed [TermW-1:0] red;    // 45*Cr
        logic signed [TermW-1:0] green;  // 11*Cb + 23*Cr, subtracted by the lanes
        logic signed [TermW-1:0] blue;   // 57*Cb
    } t_chroma_terms;

    typedef struct packed {
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
    } t_rgb_pixel;

endpackage

// ===== src/yuv2rgb_chroma.sv =====
`timescale 1ns / 1ps
// Shared chroma weighting: removes the 128 offset and forms the weighted terms.
// Depends on yuv2rgb_pkg.
module yuv2rgb_chroma
    import yuv2rgb_pkg::*;
(
    input  logic [ByteW-1:0] i_chroma_blue,
    input  logic [ByteW-1:0] i_chroma_red,
    output t_chroma_terms    o_terms
);

    localparam logic signed [TermW-1:0] CoefRCr = TermW'(45);
    localparam logic signed [TermW-1:0] CoefGCb = TermW'(11);
    localparam logic signed [TermW-1:0] CoefGCr = TermW'(23);
    localparam logic signed [TermW-1:0] CoefBCb = TermW'(57);

    logic signed [ByteW-1:0] cb_s;
    logic signed [ByteW-1:0] cr_s;
    logic signed [TermW-1:0] cb_x;
    logic signed [TermW-1:0] cr_x;

    // Subtracting 128 from an offset byte is the same as inverting its top bit.
    assign cb_s = {~i_chroma_blue[ByteW-1], i_chroma_blue[ByteW-2:0]};
    assign cr_s = {~i_chroma_red[ByteW-1], i_chroma_red[ByteW-2:0]};
    assign cb_x = TermW'(cb_s);
    assign cr_x = TermW'(cr_s);

    assign o_terms.red   = cr_x * CoefRCr;
    assign o_terms.green = cb_x * CoefGCb + cr_x * CoefGCr;
    assign o_terms.blue  = cb_x * CoefBCb;

endmodule

// ===== src/yuv2rgb_lane.sv =====
`timescale 1ns / 1ps
// One pixel lane: adds the luma base to the shared chroma terms and clamps.
// Depends on yuv2rgb_pkg.
module yuv2rgb_lane
    import yuv2rgb_pkg::*;
(
    input  logic [ByteW-1:0] i_luma,
    input  t_chroma_terms    i_terms,
    output t_rgb_pixel       o_pixel
);

    localparam int unsigned SumW = 16;
    localparam logic signed [SumW-1:0] SatHigh = SumW'(32 * 255);

    function automatic logic [ByteW-1:0] clamp_color(input logic signed [SumW-1:0] sum);
        logic [ByteW-1:0] res;
        priority if (sum <= 0) begin
            res = '0;
        end else if (sum >= SatHigh) begin
            res = '1;
        end else begin
            res = sum[ByteW+4:5];
        end
        return res;
    endfunction

    logic signed [SumW-1:0] base;
    logic signed [SumW-1:0] sum_r;
    logic signed [SumW-1:0] sum_g;
    logic signed [SumW-1:0] sum_b;

    assign base  = $signed({3'b000, i_luma, 5'b00000});
    assign sum_r = base + SumW'(i_terms.red);
    assign sum_g = base - SumW'(i_terms.green);
    assign sum_b = base + SumW'(i_terms.blue);

    assign o_pixel.red   = clamp_color(sum_r);
    assign o_pixel.green = clamp_color(sum_g);
    assign o_pixel.blue  = clamp_color(sum_b);

endmodule

// ===== src/yuyv_to_rgb_converter_top.sv =====
`timescale 1ns / 1ps
// Top level of the YUYV 4:2:2 to RGB888 converter: handshake, pipeline registers,
// the shared chroma stage, two pixel lanes and the merging output register.
// Depends on yuv2rgb_pkg, yuv2rgb_chroma and yuv2rgb_lane.
//
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_stall   i_data (t_yuyv_in), one macropixel
//  output   out        o_valid / i_stall   o_data (t_rgb_out), two RGB888 pixels
//
// One transaction is accepted every clock cycle unless o_stall is high; each result
// passes through the two pipeline stages (chroma weighting, then the lane sums,
// clamps and merge into the output register).
// Reset (synchronous, active low) clears only the stage valid bits.
// A stall on the output holds the output register; the chroma stage keeps
// accepting until it too is full, so o_stall rises only when both stages hold data.
module yuyv_to_rgb_converter_top
    import yuv2rgb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_yuyv_in i_data,
    output logic     o_stall,
    output logic     o_valid,
    output t_rgb_out o_data,
    input  logic     i_stall
);

    // First stage: lumas and frame flag carried alongside the weighted chroma.
    typedef struct packed {
        logic [ByteW-1:0] first_luma;
        logic [ByteW-1:0] second_luma;
        logic             end_of_frame;
        t_chroma_terms    terms;
    } t_stage1;

    logic          r_s1_valid;
    logic          n_s1_valid;
    t_stage1       r_s1;
    t_stage1       n_s1;
    logic          r_out_valid;
    logic          n_out_valid;
    t_rgb_out      r_out;
    t_rgb_out      n_out;

    logic          adv_out;
    logic          adv_s1;
    t_chroma_terms terms;
    t_rgb_pixel    pix_first;
    t_rgb_pixel    pix_second;

    // The output register moves when it is empty or being taken; the first
    // stage moves when it is empty or its content moves on.
    assign adv_out = !r_out_valid || !i_stall;
    assign adv_s1  = !r_s1_valid || adv_out;
    assign o_stall = !adv_s1;

    yuv2rgb_chroma u_chroma (
        .i_chroma_blue (i_data.chroma_blue),
        .i_chroma_red  (i_data.chroma_red),
        .o_terms       (terms)
    );

    // Both lanes see the same registered chroma terms, each with its own luma.
    yuv2rgb_lane u_lane_first (
        .i_luma  (r_s1.first_luma),
        .i_terms (r_s1.terms),
        .o_pixel (pix_first)
    );

    yuv2rgb_lane u_lane_second (
        .i_luma  (r_s1.second_luma),
        .i_terms (r_s1.terms),
        .o_pixel (pix_second)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (adv_s1) begin
            n_s1_valid        = i_valid;
            n_s1.first_luma   = i_data.first_luma;
            n_s1.second_luma  = i_data.second_luma;
            n_s1.end_of_frame = i_data.end_of_frame;
            n_s1.terms        = terms;
        end

        // Merge the two lane results into one output transaction.
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (adv_out) begin
            n_out_valid        = r_s1_valid;
            n_out.first_red    = pix_first.red;
            n_out.first_green  = pix_first.green;
            n_out.first_blue   = pix_first.blue;
            n_out.second_red   = pix_second.red;
            n_out.second_green = pix_second.green;
            n_out.second_blue  = pix_second.blue;
            n_out.frame_done   = r_s1.end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== src/yuv2rgb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the converter top level, with its bind statement.
// Depends on yuv2rgb_pkg and yuyv_to_rgb_converter_top.
module yuv2rgb_checker
    import yuv2rgb_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_stall,
    input logic     o_valid,
    input t_rgb_out o_data,
    input logic     i_stall
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output transaction changed while stalled");

    // The pipeline never pushes back while the output side is free.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output was not stalled");

    // A transaction reaches the output through the first stage and output registers when nothing stalls it.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall |=> o_valid)
        else $error("result missing two cycles after an unstalled transaction");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind yuyv_to_rgb_converter_top yuv2rgb_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);

// ===== dv/tb_yuyv_to_rgb_converter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for yuyv_to_rgb_converter_top: macropixels go in over a
// valid/stall channel and each RGB pixel pair is checked against a local color model.
// Depends on yuv2rgb_pkg and the converter RTL.
module tb_yuyv_to_rgb_converter_top;
    import yuv2rgb_pkg::*;

    // Timing of the bench. The clock period is 12 ns and reset is held at the start of the run.
    localparam int unsigned HalfPeriod    = 6;
    localparam int unsigned ResetCycles   = 2;
    // The block has two pipeline stages, so the drain wait at the end is ample.
    localparam int unsigned DrainCycles   = 8;
    // Length of the long receiver hold-off used to fill the pipeline.
    localparam int unsigned HoldOffCycles = 300;
    // Cycles without any accepted transaction before the run is declared hung.
    // The longest legitimate quiet stretch is the hold-off above, so this is well clear.
    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned RandomItems   = 700;

    // Color conversion constants, all sums in units of 1/32.
    localparam int ChromaOffset = 128;
    localparam int RedFromCr    = 45;
    localparam int GreenFromCb  = 11;
    localparam int GreenFromCr  = 23;
    localparam int BlueFromCb   = 57;
    localparam int SaturateSum  = 32 * 255;

    // Receiver stall patterns. Each one runs for a random number of cycles.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } t_stall_mode;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_yuyv_in i_data  = '0;
    logic     o_stall;
    logic     o_valid;
    t_rgb_out o_data;
    logic     i_stall = 1'b0;

    // Expected pixel pairs, oldest first, pushed when an input transaction is accepted.
    t_rgb_out    expected_pixels[$];
    int unsigned error_count      = 0;
    // Set by a test to request one long hold-off; cleared by the receiver process.
    bit          hold_off_pending = 1'b0;

    yuyv_to_rgb_converter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always #(HalfPeriod) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Color model
    // ------------------------------------------------------------------

    // A sum at or below zero saturates to black, a sum at or above 32*255 saturates
    // to full scale, and anything between is simply scaled down by 32.
    function automatic logic [ByteW-1:0] clamp_channel(input int sum);
        if (sum <= 0) begin
            return '0;
        end
        if (sum >= SaturateSum) begin
            return '1;
        end
        return ByteW'(sum >>> 5);
    endfunction

    function automatic t_rgb_pixel convert_pixel(input logic [ByteW-1:0] luma,
                                                 input int cb, input int cr);
        t_rgb_pixel pix;
        int         base;
        base      = 32 * int'(luma);
        pix.red   = clamp_channel(base + RedFromCr * cr);
        pix.green = clamp_channel(base - GreenFromCb * cb - GreenFromCr * cr);
        pix.blue  = clamp_channel(base + BlueFromCb * cb);
        return pix;
    endfunction

    // Both pixels of a macropixel share the chroma pair; only the luma differs.
    function automatic t_rgb_out convert_macropixel(input t_yuyv_in px);
        t_rgb_out   res;
        t_rgb_pixel first_pix;
        t_rgb_pixel second_pix;
        int         cb;
        int         cr;
        cb             = int'(px.chroma_blue) - ChromaOffset;
        cr             = int'(px.chroma_red) - ChromaOffset;
        first_pix      = convert_pixel(px.first_luma, cb, cr);
        second_pix     = convert_pixel(px.second_luma, cb, cr);
        res.first_red    = first_pix.red;
        res.first_green  = first_pix.green;
        res.first_blue   = first_pix.blue;
        res.second_red   = second_pix.red;
        res.second_green = second_pix.green;
        res.second_blue  = second_pix.blue;
        res.frame_done   = px.end_of_frame;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_yuyv_in make_macropixel(input logic [ByteW-1:0] y0,
                                                 input logic [ByteW-1:0] cb,
                                                 input logic [ByteW-1:0] y1,
                                                 input logic [ByteW-1:0] cr,
                                                 input logic eof);
        t_yuyv_in px;
        px.first_luma   = y0;
        px.chroma_blue  = cb;
        px.second_luma  = y1;
        px.chroma_red   = cr;
        px.end_of_frame = eof;
        return px;
    endfunction

    // Mostly uniform bytes; now and then 0, 255 or the 128 chroma midpoint, so
    // that both saturation limits are hit often, not just by luck.
    function automatic logic [ByteW-1:0] random_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return ByteW'(ChromaOffset);
            default: return ByteW'($urandom);
        endcase
    endfunction

    function automatic t_yuyv_in random_macropixel();
        return make_macropixel(random_byte(), random_byte(), random_byte(), random_byte(),
                               $urandom_range(0, 15) == 0);
    endfunction

    // Offers one macropixel and returns at the edge where it is accepted. Must be
    // called right after a rising edge. The payload stays put while the block stalls.
    task automatic send_macropixel(input t_yuyv_in px);
        i_valid <= 1'b1;
        i_data  <= px;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles != 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Holds the input idle until every expected pixel pair has come out.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Range corners, neutral chroma, and the exact saturation boundaries.
    task automatic test_directed_corners();
        send_macropixel(make_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        send_macropixel(make_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        send_macropixel(make_macropixel(8'd0,   8'd255, 8'd255, 8'd0,   1'b0));
        send_macropixel(make_macropixel(8'd255, 8'd0,   8'd0,   8'd255, 1'b0));
        // Neutral chroma: sums are exactly 32*Y, so zero and 32*255 land on the edges.
        send_macropixel(make_macropixel(8'd0,   8'd128, 8'd255, 8'd128, 1'b0));
        send_macropixel(make_macropixel(8'd254, 8'd128, 8'd1,   8'd128, 1'b0));
        send_macropixel(make_macropixel(8'd128, 8'd128, 8'd127, 8'd128, 1'b1));
        // Just below and above the low limit on the red sum (Y=1, Cr=-1 gives -13).
        send_macropixel(make_macropixel(8'd1,   8'd128, 8'd2,   8'd127, 1'b0));
        // Strong negative chroma drives green high; red and blue go to black in the first pixel.
        send_macropixel(make_macropixel(8'd16,  8'd0,   8'd235, 8'd0,   1'b0));
        // Strong positive chroma pushes blue past full scale in both pixels, red in the first.
        send_macropixel(make_macropixel(8'd200, 8'd255, 8'd60,  8'd255, 1'b0));
        // Alternating bit patterns in every byte.
        send_macropixel(make_macropixel(8'hAA,  8'h55,  8'h55,  8'hAA,  1'b1));
        send_macropixel(make_macropixel(8'h55,  8'hAA,  8'hAA,  8'h55,  1'b0));
        send_macropixel(make_macropixel(8'd235, 8'd16,  8'd16,  8'd240, 1'b0));
        send_macropixel(make_macropixel(8'd81,  8'd90,  8'd145, 8'd240, 1'b1));
        idle_sender(1);
    endtask

    // Long random stream sent in bursts with random gaps, including some bursts with
    // no gaps at all so the pipeline runs at full rate for a while.
    task automatic test_random_stream();
        int unsigned sent;
        int unsigned burst_len;
        sent = 0;
        while (sent < RandomItems) begin
            burst_len = $urandom_range(1, 40);
            repeat (burst_len) begin
                send_macropixel(random_macropixel());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_sender($urandom_range(0, 6));
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering, so
    // both stages fill and the block has to stall its input.
    task automatic test_output_backpressure();
        hold_off_pending = 1'b1;
        repeat (60) begin
            send_macropixel(random_macropixel());
        end
        idle_sender(1);
    endtask

    // The sender stops until the block is empty, then starts again from an idle pipe.
    task automatic test_drain_and_restart();
        wait_for_drain();
        @(posedge i_clk);
        repeat (20) begin
            send_macropixel(random_macropixel());
        end
        idle_sender(1);
    endtask

    // ------------------------------------------------------------------
    // Receiver: a changing stall pattern, plus the long hold-off on request.
    // Exactly one assignment to i_stall per clock edge.
    // ------------------------------------------------------------------
    initial begin : receiver_stall
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_left        = HoldOffCycles - 1;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:      i_stall <= 1'b0;
                    STALL_LIGHT:     i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:     i_stall <= ($urandom_range(0, 3) != 0);
                    STALL_ALTERNATE: i_stall <= ~i_stall;
                    default:         i_stall <= 1'b0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard. Both channels are sampled at the rising edge, where every signal
    // still holds the value it had before the edge, since the bench and the block
    // both update on nonblocking assignments.
    // ------------------------------------------------------------------
    task automatic check_channel(input string name, input logic [ByteW-1:0] want,
                                 input logic [ByteW-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_rgb_out want;
        if (i_rst_n) begin
            // Prediction is pushed first; the pipeline latency keeps a result from
            // ever leaving in the same cycle its input transaction enters.
            if (i_valid && !o_stall) begin
                expected_pixels.push_back(convert_macropixel(i_data));
            end
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t ns: unexpected result transaction, expected none, actual %h",
                             $time, o_data);
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_channel("first_red",    want.first_red,    o_data.first_red);
                    check_channel("first_green",  want.first_green,  o_data.first_green);
                    check_channel("first_blue",   want.first_blue,   o_data.first_blue);
                    check_channel("second_red",   want.second_red,   o_data.second_red);
                    check_channel("second_green", want.second_green, o_data.second_green);
                    check_channel("second_blue",  want.second_blue,  o_data.second_blue);
                    check_channel("frame_done",   ByteW'(want.frame_done),
                                  ByteW'(o_data.frame_done));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no transaction moves on either channel for too long.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t ns: no transaction for %0d cycles", $time, WatchdogLimit);
        $display("yuyv_to_rgb_converter_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_stream();
        test_output_backpressure();
        test_drain_and_restart();
        test_random_stream();

        // Let the pipeline empty out, then give stray results a chance to show up.
        wait_for_drain();
        repeat (DrainCycles) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time,
                     expected_pixels.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("yuyv_to_rgb_converter_top test passed");
        end else begin
            $display("yuyv_to_rgb_converter_top test failed");
        end
        $finish;
    end

endmodule
